/* hdl/rational_reduce_defines.svh */
// ----------------------------------------------------------------------------
// Rational reduction assertion macros
// Shared concurrent assertion forms for the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_REDUCE_DEFINES_SVH
`define RATIONAL_REDUCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rr_pkg.sv */
// ----------------------------------------------------------------------------
// Rational reduction package
// Word width, status codes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rr_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    localparam logic [WORD_BITS-1:0] WORD_SIGN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_NEG_OVF  = 2'd2;

    typedef struct packed {
        logic load;
        logic shift_both;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic both_even;
        logic a_zero;
        logic div_last;
    } t_dp_stat;

endpackage

/* hdl/rr_in_if.sv */
// ----------------------------------------------------------------------------
// Rational reduction input channel
// Valid/ready channel carrying one numerator and denominator pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rr_in_if;
    import rr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] num_in;
    logic signed [WORD_BITS-1:0] den_in;

    modport source (output valid, output num_in, output den_in, input ready);
    modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

/* hdl/rr_out_if.sv */
// ----------------------------------------------------------------------------
// Rational reduction output channel
// Valid/ready channel carrying the reduced fraction and its status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rr_out_if;
    import rr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] num_out;
    logic        [WORD_BITS-2:0] den_out;
    logic        [1:0]           status;

    modport source (output valid, output num_out, output den_out, output status,
                    input ready);
    modport sink   (input valid, input num_out, input den_out, input status,
                    output ready);
endinterface

/* hdl/rr_datapath.sv */
// ----------------------------------------------------------------------------
// Rational reduction datapath
// Sign handling, binary gcd registers, two restoring dividers and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_reduce_defines.svh"

module rr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [rr_pkg::WORD_BITS-1:0] i_num_in,
    input  logic signed [rr_pkg::WORD_BITS-1:0] i_den_in,
    input  rr_pkg::t_dp_cmd                     i_cmd,
    output rr_pkg::t_dp_stat                    o_stat,
    output logic signed [rr_pkg::WORD_BITS-1:0] o_num_out,
    output logic        [rr_pkg::WORD_BITS-2:0] o_den_out,
    output logic        [1:0]                   o_status
);
    import rr_pkg::*;

    localparam int W = WORD_BITS;

    // One restoring division step: returns {remainder, dividend/quotient}.
    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                                input logic [W-1:0] quo,
                                                input logic [W-1:0] dvs);
        logic [W+1:0] trial;
        trial = {1'b0, rem, quo[W-1]} - {2'b00, dvs};
        if (trial[W+1]) begin
            div_step = {rem[W-2:0], quo[W-1], quo[W-2:0], 1'b0};
        end else begin
            div_step = {trial[W-1:0], quo[W-2:0], 1'b1};
        end
    endfunction

    logic [W-1:0]        n_raw;
    logic [W-1:0]        d_raw;
    logic [W-1:0]        n_abs;
    logic [W-1:0]        d_abs;
    logic [1:0]          n_status;
    logic [W:0]          diff_ab;
    logic [W-1:0]        diff_ba;
    logic [2*W-1:0]      step_a;
    logic [2*W-1:0]      step_d;

    logic [W-1:0]        r_an;
    logic [W-1:0]        r_ad;
    logic                r_nneg;
    logic [1:0]          r_status;
    logic [W-1:0]        r_a;
    logic [W-1:0]        r_b;
    logic [CNT_BITS-1:0] r_k;
    logic [W-1:0]        r_g;
    logic [W-1:0]        r_qa;
    logic [W-1:0]        r_ra;
    logic [W-1:0]        r_qd;
    logic [W-1:0]        r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic [W-1:0]        r_num_out;
    logic [W-2:0]        r_den_out;
    logic [1:0]          r_status_out;

    always_comb begin
        n_raw = $unsigned(i_num_in);
        d_raw = $unsigned(i_den_in);
        // Magnitudes are taken directly; the sign of the result is the
        // exclusive-or of the input signs.
        n_abs = n_raw[W-1] ? (W'(0) - n_raw) : n_raw;
        d_abs = d_raw[W-1] ? (W'(0) - d_raw) : d_raw;
        if (d_raw == '0) begin
            n_status = ST_ZERO_DEN;
        end else if (d_raw[W-1] && (d_raw == WORD_SIGN || n_raw == WORD_SIGN)) begin
            n_status = ST_NEG_OVF;
        end else begin
            n_status = ST_OK;
        end
    end

    assign diff_ab = {1'b0, r_a} - {1'b0, r_b};
    assign diff_ba = r_b - r_a;
    assign step_a  = div_step(r_ra, r_qa, r_g);
    assign step_d  = div_step(r_rd, r_qd, r_g);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an     <= n_abs;
            r_ad     <= d_abs;
            r_nneg   <= n_raw[W-1] ^ d_raw[W-1];
            r_status <= n_status;
            r_a      <= n_abs;
            r_b      <= d_abs;
            r_k      <= '0;
        end
        if (i_cmd.shift_both) begin
            r_a <= r_a >> 1;
            r_b <= r_b >> 1;
            r_k <= r_k + CNT_BITS'(1);
        end
        if (i_cmd.gcd_step) begin
            if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (!diff_ab[W]) begin
                r_a <= {1'b0, diff_ab[W-1:1]};
            end else begin
                r_a <= {1'b0, diff_ba[W-1:1]};
                r_b <= r_a;
            end
        end
        if (i_cmd.div_start) begin
            r_g   <= r_b << r_k;
            r_qa  <= r_an;
            r_qd  <= r_ad;
            r_ra  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_ra  <= step_a[2*W-1:W];
            r_qa  <= step_a[W-1:0];
            r_rd  <= step_d[2*W-1:W];
            r_qd  <= step_d[W-1:0];
            r_cnt <= r_cnt + CNT_BITS'(1);
        end
        if (i_cmd.out_load) begin
            r_status_out <= r_status;
            if (r_status != ST_OK) begin
                r_num_out <= '0;
                r_den_out <= '0;
            end else begin
                r_num_out <= r_nneg ? (W'(0) - r_qa) : r_qa;
                r_den_out <= r_qd[W-2:0];
            end
        end
    end

    assign o_stat.err       = (r_status != ST_OK);
    assign o_stat.both_even = !r_a[0] && !r_b[0];
    assign o_stat.a_zero    = (r_a == '0);
    assign o_stat.div_last  = (r_cnt == CNT_BITS'(W - 1));

    assign o_num_out = $signed(r_num_out);
    assign o_den_out = r_den_out;
    assign o_status  = r_status_out;

    // The gcd loop keeps at least one operand odd, and the divisor is never zero.
    `RR_ASSERT_SAME(a_gcd_odd, i_clk, i_rst_n, i_cmd.gcd_step, r_a[0] || r_b[0], "gcd operands both even")
    `RR_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, i_cmd.div_step, r_g != '0, "divisor is zero")
endmodule

/* hdl/rr_ctrl.sv */
// ----------------------------------------------------------------------------
// Rational reduction controller
// Sequences load, common-factor shifts, binary gcd, division and output
// hand-off, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_reduce_defines.svh"

module rr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rr_pkg::t_dp_cmd  o_cmd,
    input  rr_pkg::t_dp_stat i_stat
);
    import rr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_TWOS;
                end
            end
            S_TWOS: begin
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else if (i_stat.both_even) begin
                    cmd.shift_both = 1'b1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.a_zero) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait only if the previous result has not yet been taken.
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `RR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_TWOS, "accepted transaction did not start")
    `RR_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before transfer")
    `RR_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && i_stat.div_last, r_state == S_DONE && r_out_valid == $past(n_out_valid), "division did not finish")
endmodule

/* hdl/rational_reduce.sv */
// ----------------------------------------------------------------------------
// Rational reduction
// Brings a signed fraction to lowest terms with a positive denominator,
// flagging a zero denominator and an overflowing sign negation.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                         Handshake
// i_in     sink       num_in, den_in                  valid/ready
// o_out    source     num_out, den_out, status        valid/ready
//
// A flagged item skips the shifts, the gcd and the division and goes on to
// the output hand-off. Otherwise an item runs T common-factor shift and
// binary gcd steps (T at most about 2*WORD_BITS), one per cycle, and then
// WORD_BITS steps of the two parallel restoring dividers. One item is in work
// at a time; the next is taken once the result sits in the output register,
// even while that result waits to be taken.
// Reset is synchronous and active low and clears only the control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_reduce (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rr_in_if.sink        i_in,
    rr_out_if.source     o_out
);
    import rr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    rr_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_num_in  (i_in.num_in),
        .i_den_in  (i_in.den_in),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_num_out (o_out.num_out),
        .o_den_out (o_out.den_out),
        .o_status  (o_out.status)
    );
endmodule
